// ===== design/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
// no dependencies; imported by spq_cell, sorted_priority_queue and the testbench
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int IN_PRIO_W = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
  } entry_t;

  // broadcast to every cell for the request being applied
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// one slot of the sorted queue chain
// depends on spq_pkg (entry_t, cell_ctrl_t)
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire logic               left_keep,
  input  wire spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t         entry,
  output logic                    keep
);
  import spq_pkg::*;

  entry_t entry_next;

  // entry stays ahead of the new one: held and priority not lower
  assign keep = occupied && (entry.prio >= ctrl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next = ctrl.new_entry;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (ctrl.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// top level of the sorted priority queue: chain of slot cells plus count and result register
// depends on spq_pkg and spq_cell
// latency: a result is presented the cycle after its request is accepted
// throughput: one request per cycle while results are taken; a stalled result holds off requests
// the rate is set by the single output register shared by every request
// reset clears the entry count and the result valid flag; slot contents are left as they are
`default_nettype none

module sorted_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        operation,
  input  wire logic signed [31:0] item_value,
  input  wire logic [15:0] item_priority,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic signed [31:0] head_value,
  output logic             head_valid,
  output logic [4:0]       occupancy,
  output logic [1:0]       status
);
  import spq_pkg::*;

  logic             accept;
  op_t              op;
  logic             is_full;
  logic             is_empty;
  cell_ctrl_t       ctrl;
  status_t          status_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_t          result_status;
  logic             result_valid_next;

  entry_t           entries [CAPACITY];
  logic             keeps   [CAPACITY];
  logic             occ     [CAPACITY];

  // a request waits only while a finished result is not yet taken
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  assign op       = op_t'(operation);
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // decide what the chain does for this request
  always_comb begin
    ctrl.insert          = 1'b0;
    ctrl.remove          = 1'b0;
    ctrl.new_entry.value = item_value;
    ctrl.new_entry.prio  = PRIO_W'(item_priority);
    status_next          = ST_OK;
    count_next           = count;
    case (op)
      OP_ENQUEUE: begin
        if (is_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ctrl.insert = accept;
          if (accept) begin
            count_next = count + CNT_W'(1);
          end
        end
      end
      OP_DEQUEUE: begin
        if (is_empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          ctrl.remove = accept;
          if (accept) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // slot k is in service order; cell 0 is the head
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    entry_t left_entry;
    logic   left_keep;
    entry_t right_entry;

    assign occ[k] = (count > CNT_W'(k));

    if (k == 0) begin : g_head
      // nothing ahead of the head: a new entry that does not stay behind lands here
      assign left_entry = ctrl.new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = entries[k-1];
      assign left_keep  = keeps[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      // the tail slot falls out of range after a removal, so its content is free
      assign right_entry = entries[k];
    end else begin : g_body
      assign right_entry = entries[k+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[k]),
      .left_entry  (left_entry),
      .left_keep   (left_keep),
      .right_entry (right_entry),
      .entry       (entries[k]),
      .keep        (keeps[k])
    );
  end

  // result handshake: load on accept, drop once taken
  always_comb begin
    result_valid_next = result_valid;
    if (accept) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_status <= status_next;
    end
  end

  // head fields follow the chain, which cannot move while a result is stalled
  assign head_valid = (count != '0);
  assign head_value = head_valid ? entries[0].value : '0;
  assign occupancy  = OCC_W'(count);
  assign status     = 2'(result_status);

endmodule

`default_nettype wire

// ===== test/sorted_priority_queue_tb.sv =====
// self-checking testbench for the sorted priority queue: directed and random requests
// depends on spq_pkg and the sorted_priority_queue top level
// a small scoreboard class predicts each head report from its own copy of the queue
`timescale 1ns / 1ps

import spq_pkg::*;

typedef struct packed {
  logic signed [VALUE_W-1:0] head_value;
  logic                      head_valid;
  logic [OCC_W-1:0]          occupancy;
  status_t                   status;
} head_report_t;

class spq_scoreboard;
  logic signed [VALUE_W-1:0] slot_value [CAPACITY];
  logic [PRIO_W-1:0]         slot_prio [CAPACITY];
  int unsigned               held = 0;
  head_report_t              head_reports [$];
  int unsigned               failures = 0;

  // sorted insert or head removal, then the head report that follows
  function void apply_request(op_t op, logic signed [VALUE_W-1:0] value,
                              logic [IN_PRIO_W-1:0] prio);
    int unsigned  pos;
    int unsigned  k;
    head_report_t rep;
    logic [PRIO_W-1:0] key;
    key = prio[PRIO_W-1:0];
    rep.status = ST_OK;
    if (op == OP_ENQUEUE) begin
      if (held >= CAPACITY) begin
        rep.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held && slot_prio[pos] >= key) pos++;
        for (k = held; k > pos; k--) begin
          slot_value[k] = slot_value[k-1];
          slot_prio[k]  = slot_prio[k-1];
        end
        slot_value[pos] = value;
        slot_prio[pos]  = key;
        held++;
      end
    end else begin
      if (held == 0) begin
        rep.status = ST_UNDERFLOW;
      end else begin
        for (k = 0; k + 1 < held; k++) begin
          slot_value[k] = slot_value[k+1];
          slot_prio[k]  = slot_prio[k+1];
        end
        held--;
      end
    end
    rep.head_valid = (held > 0);
    rep.head_value = (held > 0) ? slot_value[0] : '0;
    rep.occupancy  = held[OCC_W-1:0];
    head_reports.push_back(rep);
  endfunction

  function void check_head_report(logic signed [VALUE_W-1:0] head_value, logic head_valid,
                                  logic [OCC_W-1:0] occupancy, logic [1:0] status);
    head_report_t exp;
    if (head_reports.size() == 0) begin
      $error("head report with no request outstanding");
      failures++;
      return;
    end
    exp = head_reports.pop_front();
    if (head_value !== exp.head_value) begin
      $error("head_value: expected %0d, got %0d", exp.head_value, head_value);
      failures++;
    end
    if (head_valid !== exp.head_valid) begin
      $error("head_valid: expected %0b, got %0b", exp.head_valid, head_valid);
      failures++;
    end
    if (occupancy !== exp.occupancy) begin
      $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy);
      failures++;
    end
    if (status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      failures++;
    end
  endfunction

  function int unsigned outstanding();
    return head_reports.size();
  endfunction
endclass

module sorted_priority_queue_tb;

  localparam int RANDOM_PER_PHASE = 263;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic                      operation = 1'b0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic [IN_PRIO_W-1:0]      item_priority = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic signed [VALUE_W-1:0] head_value;
  logic                      head_valid;
  logic [OCC_W-1:0]          occupancy;
  logic [1:0]                status;

  // idle and stall odds in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  spq_scoreboard sb = new;

  sorted_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .item_value    (item_value),
    .item_priority (item_priority),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .head_value    (head_value),
    .head_valid    (head_valid),
    .occupancy     (occupancy),
    .status        (status)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random back-pressure, one update per edge
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor: signals read here still hold their pre-edge values
  // check first, the report at this edge always belongs to an earlier request
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        sb.check_head_report(head_value, head_valid, occupancy, status);
      end
      if (item_valid && !item_stall) begin
        sb.apply_request(op_t'(operation), item_value, item_priority);
      end
    end
  end

  // present one request, with random idle cycles ahead of it, and wait for acceptance
  // while idle the payload wanders so that ignored fields get exercised too
  task automatic send_request(input op_t op, input logic signed [VALUE_W-1:0] value,
                              input logic [IN_PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid    <= 1'b0;
      item_value    <= $urandom;
      item_priority <= IN_PRIO_W'($urandom);
      operation     <= 1'($urandom_range(1));
      @(posedge clk);
    end
    item_valid    <= 1'b1;
    operation     <= op;
    item_value    <= value;
    item_priority <= prio;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // random priority: narrow range for lots of ties, full range, or the two extremes
  function automatic logic [IN_PRIO_W-1:0] pick_priority(int unsigned mode);
    case (mode)
      0: begin
        return IN_PRIO_W'($urandom_range(3));
      end
      1: begin
        return IN_PRIO_W'($urandom);
      end
      default: begin
        return $urandom_range(1) ? {IN_PRIO_W{1'b1}} : '0;
      end
    endcase
  endfunction

  // random traffic in bursts; each burst leans toward filling, draining or neither
  // so the queue swings between empty and full with random content
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stl_pct);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned enq_pct;
    int unsigned prio_mode;
    int unsigned i;
    op_t         op;
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    sent = 0;
    while (sent < RANDOM_PER_PHASE) begin
      burst_len = $urandom_range(40, 4);
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      prio_mode = $urandom_range(2);
      for (i = 0; i < burst_len && sent < RANDOM_PER_PHASE; i++) begin
        op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        send_request(op, $urandom, pick_priority(prio_mode));
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    // dequeue from an empty queue is an underflow
    send_request(OP_DEQUEUE, 32'sd5, 16'd7);
    // value extremes at the priority extremes; the top priority jumps the queue
    send_request(OP_ENQUEUE, 32'sh7fffffff, 16'h0000);
    send_request(OP_ENQUEUE, 32'sh80000000, 16'hffff);
    // equal priorities go behind the ones already held
    send_request(OP_ENQUEUE, -32'sd1, 16'hffff);
    send_request(OP_ENQUEUE, 32'sd0, 16'h0000);
    // fill to capacity with a mix of ties and alternating bit patterns
    for (i = 0; i < CAPACITY - 4; i++) begin
      send_request(OP_ENQUEUE, (i % 2) ? 32'sh55555555 : 32'shaaaaaaaa,
                   (i % 3 == 0) ? 16'h5555 : 16'haaaa);
    end
    // full queue drops the pair
    send_request(OP_ENQUEUE, 32'sd12345, 16'hffff);

    // random part across the idling phases
    run_random_phase(0, 0);
    run_random_phase(59, 0);
    run_random_phase(0, 59);
    run_random_phase(28, 28);

    item_valid <= 1'b0;
    // let the monitor log the last request before counting what is left
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    // give any stray report a chance to show up
    repeat (8) @(posedge clk);

    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
